>>> src/dpvc_pkg.sv
// Shared types and constants for the depth pixel voxel carving block.
`default_nettype none
package dpvc_pkg;

    // Input action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_INTEG = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_IFX  = 3'd0;
    localparam logic [2:0] CFG_IFY  = 3'd1;
    localparam logic [2:0] CFG_CCOL = 3'd2;
    localparam logic [2:0] CFG_CROW = 3'd3;
    localparam logic [2:0] CFG_CW   = 3'd4;
    localparam logic [2:0] CFG_CH   = 3'd5;
    localparam logic [2:0] CFG_CD   = 3'd6;
    localparam logic [2:0] CFG_OFF  = 3'd7;

    // Cell codes
    localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [1:0] CELL_EMPTY    = 2'd1;
    localparam logic [1:0] CELL_OBSTACLE = 2'd2;

    // Datapath widths: Q.20 coordinates and axis numerators
    localparam int QXW = 48;
    localparam int NW  = 50;
    localparam int FRAC = 20;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_CLEAR,
        OP_INTEG,
        OP_READ
    } t_op;

    typedef struct packed {
        logic [19:0]        ifx;
        logic [19:0]        ify;
        logic [9:0]         ccol;
        logic [9:0]         crow;
        logic [9:0]         cw;
        logic [9:0]         ch;
        logic [9:0]         cd;
        logic signed [11:0] off;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic signed [10:0] dc;
        logic signed [10:0] dr;
        logic [13:0]        depth;
        logic [12:0]        addr;
    } t_cmd;

    typedef struct packed {
        logic [1:0] cell_state;
        logic       hit;
    } t_res;

endpackage
`default_nettype wire

>>> src/dpvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dpvc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> src/dpvc_fifo.sv
// Small register queue used between stages and at the result side.
`default_nettype none
module dpvc_fifo #(
    parameter int W = 8,
    parameter int D = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);

    logic [W-1:0]  r_mem [D];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(D));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(D - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(D - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

>>> src/dpvc_front.sv
// Front end: accepts items, classifies the action and queues commands.
`default_nettype none
module dpvc_front #(
    parameter int CELLS = 8192
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [1:0]       i_action,
    input  wire logic [9:0]       i_pixel_col,
    input  wire logic [9:0]       i_pixel_row,
    input  wire logic [13:0]      i_depth_mm,
    input  wire logic             i_depth_valid,
    input  wire logic [12:0]      i_cell_index,
    input  wire dpvc_pkg::t_cfg   i_cfg,
    output logic                  o_full,
    input  wire logic             i_pop,
    output dpvc_pkg::t_cmd        o_cmd,
    output logic                  o_empty
);
    dpvc_pkg::t_cmd cmd;

    always_comb begin
        cmd.dc    = $signed({1'b0, i_pixel_col}) - $signed({1'b0, i_cfg.ccol});
        cmd.dr    = $signed({1'b0, i_pixel_row}) - $signed({1'b0, i_cfg.crow});
        cmd.depth = i_depth_mm;
        cmd.addr  = i_cell_index;
        case (i_action)
            dpvc_pkg::ACT_CLEAR: cmd.op = dpvc_pkg::OP_CLEAR;
            dpvc_pkg::ACT_INTEG: cmd.op = i_depth_valid ? dpvc_pkg::OP_INTEG
                                                        : dpvc_pkg::OP_NOP;
            // out-of-grid reads return unknown without touching memory
            dpvc_pkg::ACT_READ:  cmd.op = (32'(i_cell_index) < CELLS) ? dpvc_pkg::OP_READ
                                                                      : dpvc_pkg::OP_NOP;
            default:             cmd.op = dpvc_pkg::OP_NOP;
        endcase
    end

    dpvc_fifo #(.W($bits(dpvc_pkg::t_cmd)), .D(2)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .i_pop   (i_pop),
        .o_data  (o_cmd),
        .o_full  (o_full),
        .o_empty (o_empty)
    );
endmodule
`default_nettype wire

>>> src/dpvc_div.sv
// Restoring divider lane: one quotient bit per step, quotient known to fit QW bits.
`default_nettype none
module dpvc_div #(
    parameter int QW = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_start,
    input  wire logic                    i_step,
    input  wire logic [dpvc_pkg::NW-1:0] i_num,
    input  wire logic [dpvc_pkg::NW-1:0] i_div,
    output logic      [QW-1:0]           o_q
);
    logic [dpvc_pkg::NW-1:0] r_rem, r_dv;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dv  <= i_div << (QW - 1);
            o_q   <= '0;
        end else if (i_step) begin
            if (r_rem >= r_dv) begin
                r_rem <= r_rem - r_dv;
                o_q   <= {o_q[QW-2:0], 1'b1};
            end else begin
                o_q   <= {o_q[QW-2:0], 1'b0};
            end
            r_dv <= r_dv >> 1;
        end
    end
endmodule
`default_nettype wire

>>> src/dpvc_back.sv
// Back end: runs clear sweeps, cell reads and ray integration against the grid RAM.
`default_nettype none
module dpvc_back #(
    parameter int GRID_U      = 16,
    parameter int GRID_V      = 64,
    parameter int GRID_W      = 8,
    parameter int RAY_STEP_MM = 50,
    parameter int CELLS       = GRID_U * GRID_V * GRID_W,
    parameter int AW          = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire dpvc_pkg::t_cfg i_cfg,
    input  wire dpvc_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_empty,
    output logic                o_cmd_pop,
    output logic                o_init,
    output logic                o_ram_we,
    output logic                o_ram_re,
    output logic [AW-1:0]       o_ram_addr,
    output logic [1:0]          o_ram_wdata,
    input  wire logic [1:0]     i_ram_rdata,
    input  wire logic           i_res_full,
    output logic                o_res_push,
    output dpvc_pkg::t_res      o_res
);
    localparam int UB  = (GRID_U > 1) ? $clog2(GRID_U) : 1;
    localparam int VB  = (GRID_V > 1) ? $clog2(GRID_V) : 1;
    localparam int WB  = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int QW0 = (UB > VB) ? UB : VB;
    localparam int QW  = ((QW0 > WB) ? QW0 : WB) + 1;
    localparam int QB  = $clog2(QW);
    localparam int QXW = dpvc_pkg::QXW;
    localparam int NW  = dpvc_pkg::NW;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_RD0, S_RD1, S_MUL1, S_MUL2, S_TEST, S_DIV,
        S_RMW0, S_RMW1, S_STEP, S_HIT, S_FILL, S_DONE
    } t_st;

    t_st                   r_st;
    logic                  r_init;
    logic [AW-1:0]         r_cnt;
    logic signed [10:0]    r_dc, r_dr;
    logic [13:0]           r_d;
    logic [12:0]           r_addr_in;
    logic signed [31:0]    r_a, r_b;
    logic signed [QXW-1:0] r_sa, r_sb, r_hx, r_hy, r_xq, r_yq;
    logic [14:0]           r_t;
    logic                  r_hitm;
    logic [QB-1:0]         r_dcnt;
    logic [WB-1:0]         r_w;
    logic [1:0]            r_res_state;
    logic                  r_res_hit;

    logic [9:0]            cw, ch, cd;
    logic signed [QXW-1:0] offq;
    logic [NW-1:0]         span_x, span_y, div_x, div_y, div_w;
    logic signed [NW-1:0]  num_x, num_y;
    logic                  in_x, in_y, in_w, to_hit, lane_start, lane_step;
    logic [QW-1:0]         q_u, q_v, q_w;
    logic [AW-1:0]         lin_ray, lin_fill;

    function automatic logic [AW-1:0] lin(input logic [QW-1:0] u, input logic [QW-1:0] v,
                                          input logic [QW-1:0] w);
        lin = AW'(32'(w) * (GRID_U * GRID_V) + 32'(v) * GRID_U + 32'(u));
    endfunction

    // zero cell size acts as 1 mm
    assign cw   = (i_cfg.cw == '0) ? 10'd1 : i_cfg.cw;
    assign ch   = (i_cfg.ch == '0) ? 10'd1 : i_cfg.ch;
    assign cd   = (i_cfg.cd == '0) ? 10'd1 : i_cfg.cd;
    assign offq = QXW'(i_cfg.off) <<< dpvc_pkg::FRAC;

    assign span_x = (NW'(GRID_U) * NW'(cw)) << dpvc_pkg::FRAC;
    assign span_y = (NW'(GRID_V) * NW'(ch)) << dpvc_pkg::FRAC;
    assign div_x  = NW'(cw) << (dpvc_pkg::FRAC + 1);
    assign div_y  = NW'(ch) << (dpvc_pkg::FRAC + 1);
    assign div_w  = NW'(cd);
    assign num_x  = (NW'(r_xq) <<< 1) + $signed(span_x);
    assign num_y  = (NW'(r_yq) <<< 1) + $signed(span_y);
    assign in_x   = !num_x[NW-1] && ($unsigned(num_x) < (span_x << 1));
    assign in_y   = !num_y[NW-1] && ($unsigned(num_y) < (span_y << 1));
    assign in_w   = 32'(r_t) < (32'(GRID_W) * 32'(cd));
    assign to_hit = !r_hitm && (r_t >= 15'(r_d));

    assign lane_start = (r_st == S_TEST) && !to_hit && in_x && in_y && in_w;
    assign lane_step  = (r_st == S_DIV);

    dpvc_div #(.QW(QW)) u_div_u (
        .i_clk(i_clk), .i_start(lane_start), .i_step(lane_step),
        .i_num($unsigned(num_x)), .i_div(div_x), .o_q(q_u)
    );
    dpvc_div #(.QW(QW)) u_div_v (
        .i_clk(i_clk), .i_start(lane_start), .i_step(lane_step),
        .i_num($unsigned(num_y)), .i_div(div_y), .o_q(q_v)
    );
    dpvc_div #(.QW(QW)) u_div_w (
        .i_clk(i_clk), .i_start(lane_start), .i_step(lane_step),
        .i_num(NW'(r_t)), .i_div(div_w), .o_q(q_w)
    );

    assign lin_ray  = lin(q_u, q_v, q_w);
    assign lin_fill = lin(q_u, q_v, QW'(r_w));

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_addr  = lin_ray;
        o_ram_wdata = dpvc_pkg::CELL_UNKNOWN;
        case (r_st)
            S_CLR: begin
                o_ram_we   = 1'b1;
                o_ram_addr = r_cnt;
            end
            S_RD0: begin
                o_ram_re   = 1'b1;
                o_ram_addr = AW'(r_addr_in);
            end
            S_RMW0: o_ram_re = 1'b1;
            S_RMW1: begin
                o_ram_we    = (i_ram_rdata == dpvc_pkg::CELL_UNKNOWN);
                o_ram_wdata = dpvc_pkg::CELL_EMPTY;
            end
            S_FILL: begin
                o_ram_we    = 1'b1;
                o_ram_addr  = lin_fill;
                o_ram_wdata = dpvc_pkg::CELL_OBSTACLE;
            end
            default: ;
        endcase
    end

    assign o_cmd_pop        = (r_st == S_IDLE) && !i_cmd_empty;
    assign o_res_push       = (r_st == S_DONE) && !i_res_full;
    assign o_res.cell_state = r_res_state;
    assign o_res.hit        = r_res_hit;
    assign o_init           = r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_CLR;
            r_init <= 1'b1;
            r_cnt  <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_dc        <= i_cmd.dc;
                        r_dr        <= i_cmd.dr;
                        r_d         <= i_cmd.depth;
                        r_addr_in   <= i_cmd.addr;
                        r_res_state <= dpvc_pkg::CELL_UNKNOWN;
                        r_res_hit   <= 1'b0;
                        r_cnt       <= '0;
                        case (i_cmd.op)
                            dpvc_pkg::OP_CLEAR: r_st <= S_CLR;
                            dpvc_pkg::OP_READ:  r_st <= S_RD0;
                            dpvc_pkg::OP_INTEG: r_st <= S_MUL1;
                            default:            r_st <= S_DONE;
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_cnt == AW'(CELLS - 1)) begin
                        r_init <= 1'b0;
                        r_st   <= r_init ? S_IDLE : S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RD0: r_st <= S_RD1;
                S_RD1: begin
                    r_res_state <= i_ram_rdata;
                    r_st        <= S_DONE;
                end
                S_MUL1: begin
                    r_a  <= 32'(r_dc) * $signed({12'd0, i_cfg.ifx});
                    r_b  <= 32'(r_dr) * $signed({12'd0, i_cfg.ify});
                    r_st <= S_MUL2;
                end
                S_MUL2: begin
                    r_sa   <= QXW'(r_a) * $signed(QXW'(RAY_STEP_MM));
                    r_sb   <= QXW'(r_b) * $signed(QXW'(RAY_STEP_MM));
                    r_hx   <= QXW'(r_a) * $signed(QXW'(r_d));
                    r_hy   <= QXW'(r_b) * $signed(QXW'(r_d)) - offq;
                    r_xq   <= '0;
                    r_yq   <= -offq;
                    r_t    <= '0;
                    r_hitm <= 1'b0;
                    r_st   <= S_TEST;
                end
                S_TEST: begin
                    if (to_hit) begin
                        r_xq   <= r_hx;
                        r_yq   <= r_hy;
                        r_t    <= 15'(r_d);
                        r_hitm <= 1'b1;
                    end else if (!(in_x && in_y && in_w)) begin
                        r_st <= r_hitm ? S_DONE : S_STEP;
                    end else begin
                        r_dcnt <= '0;
                        r_st   <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == QB'(QW - 1)) begin
                        r_st <= r_hitm ? S_HIT : S_RMW0;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_RMW0: r_st <= S_RMW1;
                S_RMW1: r_st <= S_STEP;
                S_STEP: begin
                    r_t  <= r_t + 15'(RAY_STEP_MM);
                    r_xq <= r_xq + r_sa;
                    r_yq <= r_yq + r_sb;
                    r_st <= S_TEST;
                end
                S_HIT: begin
                    r_w  <= WB'(q_w);
                    r_st <= S_FILL;
                end
                S_FILL: begin
                    if (r_w == WB'(GRID_W - 1)) begin
                        r_res_hit <= 1'b1;
                        r_st      <= S_DONE;
                    end else begin
                        r_w <= r_w + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/depth_pixel_voxel_carving.sv
// Top level of the depth pixel voxel carving block.
`default_nettype none
// Keeps a GRID_U x GRID_V x GRID_W grid of 2-bit cells (unknown, empty, obstacle) in one
// RAM. Each request is a clear, an integrate of one depth pixel, or a read of one cell, and
// gives exactly one result. Requests enter through push/full into a two-entry command
// queue; results leave through empty/pop from a two-entry result queue, so both sides can
// stall independently. After reset the grid RAM is swept to unknown, one cell per cycle,
// over all GRID_U*GRID_V*GRID_W cells (8192 by default); full stays high during the sweep.
// Configuration writes are accepted at any time but must only be issued while idle.
// Work per request, done by the back-end sequencer through the single RAM port:
//   clear: one RAM write per cell; read: one RAM read; invalid or unused request: none
//   integrate: setup, then a divide and a read-modify-write per ray sample inside the
//   grid and a skip per sample outside it, then, when the hit lands in the grid, a divide
//   and one obstacle write per cell from the hit cell to the back of the grid. There are
//   S = ceil(depth / RAY_STEP_MM) ray samples; QW (7 by default) is the divider width,
//   one quotient bit per cycle with the three axis indices computed in parallel.
module depth_pixel_voxel_carving #(
    parameter int GRID_U      = 16,
    parameter int GRID_V      = 64,
    parameter int GRID_W      = 8,
    parameter int RAY_STEP_MM = 50
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request side
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_action,
    input  wire logic [9:0]  i_pixel_col,
    input  wire logic [9:0]  i_pixel_row,
    input  wire logic [13:0] i_depth_mm,
    input  wire logic        i_depth_valid,
    input  wire logic [12:0] i_cell_index,
    // result side
    output logic             empty,
    input  wire logic        pop,
    output logic [1:0]       o_cell_state,
    output logic             o_hit_marked,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_wdata
);
    localparam int CELLS = GRID_U * GRID_V * GRID_W;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    dpvc_pkg::t_cfg r_cfg;
    dpvc_pkg::t_cmd cmd;
    dpvc_pkg::t_res res, res_out;
    logic           cmd_full, cmd_empty, cmd_pop, init;
    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_addr;
    logic [1:0]     ram_wdata, ram_rdata;
    logic           res_full, res_push;

    // Configuration registers, reset to the default camera model.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ifx  <= 20'd2097;
            r_cfg.ify  <= 20'd2097;
            r_cfg.ccol <= 10'd320;
            r_cfg.crow <= 10'd240;
            r_cfg.cw   <= 10'd100;
            r_cfg.ch   <= 10'd16;
            r_cfg.cd   <= 10'd75;
            r_cfg.off  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpvc_pkg::CFG_IFX:  r_cfg.ifx  <= i_cfg_wdata;
                dpvc_pkg::CFG_IFY:  r_cfg.ify  <= i_cfg_wdata;
                dpvc_pkg::CFG_CCOL: r_cfg.ccol <= i_cfg_wdata[9:0];
                dpvc_pkg::CFG_CROW: r_cfg.crow <= i_cfg_wdata[9:0];
                dpvc_pkg::CFG_CW:   r_cfg.cw   <= i_cfg_wdata[9:0];
                dpvc_pkg::CFG_CH:   r_cfg.ch   <= i_cfg_wdata[9:0];
                dpvc_pkg::CFG_CD:   r_cfg.cd   <= i_cfg_wdata[9:0];
                dpvc_pkg::CFG_OFF:  r_cfg.off  <= $signed(i_cfg_wdata[11:0]);
                default: ;
            endcase
        end
    end

    // No requests while the post-reset sweep runs.
    assign full = cmd_full || init;

    dpvc_front #(.CELLS(CELLS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push && !full),
        .i_action      (i_action),
        .i_pixel_col   (i_pixel_col),
        .i_pixel_row   (i_pixel_row),
        .i_depth_mm    (i_depth_mm),
        .i_depth_valid (i_depth_valid),
        .i_cell_index  (i_cell_index),
        .i_cfg         (r_cfg),
        .o_full        (cmd_full),
        .i_pop         (cmd_pop),
        .o_cmd         (cmd),
        .o_empty       (cmd_empty)
    );

    dpvc_back #(
        .GRID_U(GRID_U), .GRID_V(GRID_V), .GRID_W(GRID_W), .RAY_STEP_MM(RAY_STEP_MM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_init      (init),
        .o_ram_we    (ram_we),
        .o_ram_re    (ram_re),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Occupancy grid: one write/read port, registered read data.
    dpvc_ram #(.WIDTH(2), .DEPTH(CELLS)) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    dpvc_fifo #(.W($bits(dpvc_pkg::t_res)), .D(2)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_cell_state = res_out.cell_state;
    assign o_hit_marked = res_out.hit;

    // Back end never pushes a result into a full queue.
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // The reset sweep writes only unknown cells and produces no results.
    a_init_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init |-> (!res_push && (!ram_we || ram_wdata == dpvc_pkg::CELL_UNKNOWN)))
        else $error("reset sweep wrote a cell or a result");

    // A command is taken only when one is queued.
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

endmodule
`default_nettype wire
